// ===== sv/tcp_pkg.sv =====
// Package: shared types, constants and codes of the timecode text parser.
`timescale 1ns / 1ps

package tcp_pkg;

	// Default width of one digit field accumulator
	localparam int FIELD_WIDTH_DEF = 21;

	// Widths of the fixed ports and of the conversion datapath
	localparam int CHAR_W        = 8;
	localparam int NOMINAL_W     = 16;
	localparam int FRAME_COUNT_W = 49;
	localparam int HOURS_W       = 20;  // holds MAX_HOURS
	localparam int MS_W          = 6;   // minutes and seconds below 60
	localparam int T1_W          = 26;  // hours * 60 + minutes
	localparam int T2_W          = 32;  // total seconds
	localparam int PROD_W        = 48;  // total seconds * nominal + frames

	// Range limits
	localparam int MAX_HOURS    = 1000000;
	localparam int MINUTE_LIMIT = 60;
	localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 16'd30;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

	// Scan phase of the current label
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BODY,
		PH_TRAIL
	} phase_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_SCAN,
		ST_CHECK,
		ST_MUL60,
		ST_MULN,
		ST_ADDF,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;
		logic check;
		logic mul60;
		logic muln;
		logic addf;
		logic emit;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== sv/tcp_if.sv =====
// Interfaces: character, result and configuration channels of the parser.
`timescale 1ns / 1ps

interface tcp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface tcp_result_if;
	logic               valid;
	logic               ready;
	logic signed [48:0] frame_count;
	logic               label_valid;

	modport source (output valid, output frame_count, output label_valid, input ready);
	modport sink (input valid, input frame_count, input label_valid, output ready);
endinterface

interface tcp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/timecode_text_parser.sv =====
// Top level: timecode text parser, controller plus datapath.
//
//  Channel     Dir  Payload                          Transfer
//  char_in     in   char_code[7:0], last_char        valid & ready
//  result_out  out  frame_count[48:0] s, label_valid  valid & ready
//  cfg         in   data[15:0] -> nominal_frames      valid & ready (ready held high)
//
// Characters are taken one per cycle while scanning. After the closing character
// the conversion runs through its steps (check, times 60, times nominal on the one
// multiplier, add frames, emit), during which char_in.ready is low.
// Emit waits while the result register holds an untaken transaction.
// arst_n clears the label state, empties the result register, sets nominal_frames to 30.
`timescale 1ns / 1ps

module timecode_text_parser #(
	parameter int FIELD_WIDTH = tcp_pkg::FIELD_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tcp_char_if.sink     char_in,
	tcp_result_if.source result_out,
	tcp_cfg_if.sink      cfg
);
	import tcp_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign char_in.ready = in_ready;

	tcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (char_in.valid),
		.in_last  (char_in.last_char),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcp_datapath #(
		.FIELD_WIDTH (FIELD_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.char_code  (char_in.char_code),
		.cfg        (cfg),
		.result_out (result_out)
	);

endmodule

// ===== sv/tcp_ctrl.sv =====
// Controller: sequences character scan and the multi-cycle frame count conversion.
`timescale 1ns / 1ps

module tcp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	input  tcp_pkg::status_t status,
	output tcp_pkg::cmd_t    cmd
);
	import tcp_pkg::*;

	state_t state_q;
	state_t state_d;

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_MUL60;
			end
			ST_MUL60: begin
				cmd.mul60 = 1'b1;
				state_d   = ST_MULN;
			end
			ST_MULN: begin
				cmd.muln = 1'b1;
				state_d  = ST_ADDF;
			end
			ST_ADDF: begin
				cmd.addf = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// Wait for the output slot, then load it and clear the label
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			default: state_d = ST_SCAN;
		endcase
	end

	// A closing character always starts the conversion
	a_last_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && in_valid && in_last) |=> (state_q == ST_CHECK))
		else $error("closing character did not start conversion");

	// Conversion runs straight through to the emit step
	a_addf_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDF) |=> (state_q == ST_EMIT))
		else $error("conversion did not reach emit");

endmodule

// ===== sv/tcp_datapath.sv =====
// Datapath: label scan registers, range checks, frame count arithmetic, result register.
`timescale 1ns / 1ps

module tcp_datapath #(
	parameter int FIELD_WIDTH = tcp_pkg::FIELD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcp_pkg::cmd_t               cmd,
	output tcp_pkg::status_t            status,
	input  logic [tcp_pkg::CHAR_W-1:0]  char_code,
	tcp_cfg_if.sink                     cfg,
	tcp_result_if.source                result_out
);
	import tcp_pkg::*;

	localparam int ACC_W = FIELD_WIDTH + 4;

	// Label scan state
	phase_t                 phase_q, phase_d;
	logic                   neg_q, neg_d;
	logic [1:0]             seen_q, seen_d;
	logic [FIELD_WIDTH-1:0] cur_q, cur_d;
	logic [FIELD_WIDTH-1:0] prev_q [3];
	logic [FIELD_WIDTH-1:0] prev_d [3];
	logic                   has_q, has_d;
	logic                   err_q, err_d;
	logic                   body_char;

	// Character classes
	logic                   is_space, is_digit, is_colon, is_sign;
	logic [ACC_W-1:0]       acc_ext, acc_next;

	// Configuration
	logic [NOMINAL_W-1:0]   nominal_q;
	logic [NOMINAL_W-1:0]   nominal_eff;

	// Conversion pipeline
	logic                   ok_s1, ok_s2, ok_s3, ok_s4;
	logic [T1_W-1:0]        t1_s1;
	logic [T2_W-1:0]        t2_s2;
	logic [PROD_W-1:0]      prod_s3;
	logic [PROD_W-1:0]      sum_s4;
	logic                   range_ok;
	logic [T1_W-1:0]        hours_ext;
	logic [T2_W-1:0]        t1_ext;
	logic [FRAME_COUNT_W-1:0] sum_ext;

	// Result register
	logic                      out_valid_q;
	logic [FRAME_COUNT_W-1:0]  out_count_q;
	logic                      out_ok_q;

	// Classify the incoming character
	assign is_space = (char_code == CHAR_SPACE) || (char_code >= CHAR_TAB && char_code <= CHAR_CR);
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign is_colon = (char_code == CHAR_COLON);
	assign is_sign  = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);

	// Accumulate one decimal digit; saturate past the field width
	assign acc_ext  = ACC_W'(cur_q);
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(char_code[3:0]);

	// Next scan state
	always_comb begin
		phase_d   = phase_q;
		neg_d     = neg_q;
		seen_d    = seen_q;
		cur_d     = cur_q;
		prev_d    = prev_q;
		has_d     = has_q;
		err_d     = err_q;
		body_char = 1'b0;
		if (cmd.emit) begin
			phase_d = PH_LEAD;
			neg_d   = 1'b0;
			seen_d  = '0;
			cur_d   = '0;
			prev_d  = '{default: '0};
			has_d   = 1'b0;
			err_d   = 1'b0;
		end else if (cmd.take) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (!is_space) begin
						phase_d = PH_BODY;
						if (is_sign) begin
							neg_d = (char_code == CHAR_MINUS);
						end else begin
							body_char = 1'b1;
						end
					end
				end
				PH_BODY: body_char = 1'b1;
				PH_TRAIL: begin
					if (!is_space) begin
						err_d = 1'b1;
					end
				end
				default: err_d = 1'b1;
			endcase
			if (body_char) begin
				if (is_digit) begin
					if (acc_next > ACC_W'({FIELD_WIDTH{1'b1}})) begin
						cur_d = '1;
					end else begin
						cur_d = acc_next[FIELD_WIDTH-1:0];
					end
					has_d = 1'b1;
				end else if (is_colon) begin
					if (!has_q || seen_q == 2'd3) begin
						err_d = 1'b1;
					end else begin
						// Shift the finished field toward the hours slot
						seen_d    = seen_q + 2'd1;
						prev_d[2] = prev_q[1];
						prev_d[1] = prev_q[0];
						prev_d[0] = cur_q;
						cur_d     = '0;
					end
					has_d = 1'b0;
				end else if (is_space) begin
					phase_d = PH_TRAIL;
				end else begin
					err_d = 1'b1;
				end
			end
		end
	end

	// Hold scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			seen_q  <= '0;
			cur_q   <= '0;
			prev_q  <= '{default: '0};
			has_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			cur_q   <= cur_d;
			prev_q  <= prev_d;
			has_q   <= has_d;
			err_q   <= err_d;
		end
	end

	// Hold frame rate register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= NOMINAL_RESET;
		end else if (cfg.valid) begin
			nominal_q <= cfg.data;
		end
	end

	assign nominal_eff = (nominal_q == '0) ? NOMINAL_W'(1) : nominal_q;

	// Check field count and ranges; fields right-aligned (prev 0 seconds, 1 minutes, 2 hours)
	assign range_ok = !err_q && has_q && (seen_q != 2'd0)
		&& (prev_q[0] < FIELD_WIDTH'(MINUTE_LIMIT))
		&& (prev_q[1] < FIELD_WIDTH'(MINUTE_LIMIT))
		&& (cur_q < FIELD_WIDTH'(nominal_eff))
		&& (prev_q[2] <= FIELD_WIDTH'(MAX_HOURS));

	assign hours_ext = T1_W'(prev_q[2][HOURS_W-1:0]);
	assign t1_ext    = T2_W'(t1_s1);
	assign sum_ext   = FRAME_COUNT_W'(sum_s4);

	// Advance conversion one step per command
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			ok_s1 <= range_ok;
			t1_s1 <= (hours_ext << 6) - (hours_ext << 2) + T1_W'(prev_q[1][MS_W-1:0]);
		end
		if (cmd.mul60) begin
			ok_s2 <= ok_s1;
			t2_s2 <= (t1_ext << 6) - (t1_ext << 2) + T2_W'(prev_q[0][MS_W-1:0]);
		end
		if (cmd.muln) begin
			ok_s3   <= ok_s2;
			prod_s3 <= PROD_W'(t2_s2) * PROD_W'(nominal_eff);
		end
		if (cmd.addf) begin
			ok_s4  <= ok_s3;
			sum_s4 <= prod_s3 + PROD_W'(cur_q[NOMINAL_W-1:0]);
		end
	end

	// Load result register on emit, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_ok_q <= ok_s4;
			if (!ok_s4) begin
				out_count_q <= '0;
			end else if (neg_q) begin
				out_count_q <= '0 - sum_ext;
			end else begin
				out_count_q <= sum_ext;
			end
		end
	end

	assign status.out_free        = !out_valid_q || result_out.ready;
	assign result_out.valid       = out_valid_q;
	assign result_out.frame_count = out_count_q;
	assign result_out.label_valid = out_ok_q;

	// An invalid label always reports a zero count
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ok_q) |-> (out_count_q == '0))
		else $error("invalid label with nonzero frame count");

	// Field index moves only on a character or a label clear
	a_seen_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.take && !cmd.emit) |=> $stable(seen_q))
		else $error("field index moved without a character");

	// Emit never overwrites an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && out_valid_q) |-> result_out.ready)
		else $error("result overwritten before it was taken");

endmodule

// ===== test/timecode_text_parser_test.sv =====
// Testbench: self-checking random and directed test of the timecode text parser.
`timescale 1ns / 1ps

module timecode_text_parser_test;
	import tcp_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int FW = FIELD_WIDTH_DEF;
	localparam longint unsigned FIELD_SAT = (64'd1 << FW) - 1;
	localparam int PHASES = 7;
	localparam int HOLD_PHASE = 5;
	localparam int HOLD_CYCLES = 80;
	localparam int CHARS_PER_PHASE = 160;
	localparam int SETTLE_CYCLES = 12;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0] code;
		logic       last;
		logic       drain;
	} char_item_t;

	typedef struct {
		logic signed [48:0] frame_count;
		logic               label_valid;
	} tc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcp_char_if   char_bus();
	tcp_result_if result_bus();
	tcp_cfg_if    cfg_bus();

	timecode_text_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_in(char_bus),
		.result_out(result_bus),
		.cfg(cfg_bus)
	);

	// Pending characters and expected results
	char_item_t char_q[$];
	tc_result_t expected_counts[$];
	logic char_taken = 1'b0;
	int mismatch_count = 0;
	int send_idle_pct = 30;
	int recv_idle_pct = 81;
	int phase_no = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// Label scanner state
	phase_t scan_ph;
	logic neg_label;
	int unsigned field_idx;
	longint unsigned field_val[4];
	logic digit_seen;
	logic bad_label;
	logic [NOMINAL_W-1:0] nominal_reg = NOMINAL_RESET;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic is_ws(logic [7:0] c);
		return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	task automatic clear_label_state();
		scan_ph = PH_LEAD;
		neg_label = 1'b0;
		field_idx = 0;
		field_val = '{0, 0, 0, 0};
		digit_seen = 1'b0;
		bad_label = 1'b0;
	endtask

	initial clear_label_state();

	// Accumulate digits, split fields, open trailing whitespace
	task automatic scan_body(logic [7:0] c);
		longint unsigned d;
		longint unsigned v;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = c - CHAR_ZERO;
			v = field_val[field_idx];
			if (v > (FIELD_SAT - d) / 10)
				v = FIELD_SAT;
			else
				v = v * 10 + d;
			field_val[field_idx] = v;
			digit_seen = 1'b1;
		end else if (c == CHAR_COLON) begin
			if (!digit_seen || field_idx >= 3)
				bad_label = 1'b1;
			else
				field_idx++;
			digit_seen = 1'b0;
		end else if (is_ws(c)) begin
			scan_ph = PH_TRAIL;
		end else begin
			bad_label = 1'b1;
		end
	endtask

	// Advance the label by one character; on the closing one compute the frame count
	task automatic scan_timecode_char(input logic [7:0] c, input logic last,
			output logic produced, output tc_result_t r);
		longint unsigned f[4];
		longint unsigned nom;
		longint unsigned total;
		int unsigned cnt;
		logic ok;
		case (scan_ph)
			PH_LEAD: begin
				if (!is_ws(c)) begin
					scan_ph = PH_BODY;
					if (c == CHAR_PLUS || c == CHAR_MINUS)
						neg_label = (c == CHAR_MINUS);
					else
						scan_body(c);
				end
			end
			PH_BODY: scan_body(c);
			default: begin
				if (!is_ws(c))
					bad_label = 1'b1;
			end
		endcase
		produced = last;
		r.frame_count = '0;
		r.label_valid = 1'b0;
		if (last) begin
			f = '{0, 0, 0, 0};
			nom = (nominal_reg == 0) ? 1 : nominal_reg;
			cnt = field_idx + 1;
			ok = !bad_label && digit_seen && cnt >= 2 && cnt <= 4;
			if (ok) begin
				// align fields from the right so the last one is frames
				for (int i = 0; i < cnt; i++)
					f[4 - cnt + i] = field_val[i];
				if (f[1] >= MINUTE_LIMIT || f[2] >= MINUTE_LIMIT || f[3] >= nom
						|| f[0] > MAX_HOURS)
					ok = 1'b0;
			end
			total = 0;
			if (ok) begin
				total = ((f[0] * MINUTE_LIMIT + f[1]) * MINUTE_LIMIT + f[2]) * nom + f[3];
				if (neg_label)
					total = -total;
			end
			r.frame_count = total[48:0];
			r.label_valid = ok;
			clear_label_state();
		end
	endtask

	// Sample handshakes, predict, and check results
	always @(posedge clk) begin : watch_ports
		tc_result_t got;
		tc_result_t want;
		logic produced;
		char_taken = 1'b0;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				nominal_reg = cfg_bus.data;
			if (char_bus.valid && char_bus.ready) begin
				char_taken = 1'b1;
				scan_timecode_char(char_bus.char_code, char_bus.last_char, produced, want);
				if (produced)
					expected_counts.insert(expected_counts.size(), want);
			end
			if (result_bus.valid && result_bus.ready) begin
				got.frame_count = result_bus.frame_count;
				got.label_valid = result_bus.label_valid;
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result, frame_count %0d label_valid %0b",
						$time, got.frame_count, got.label_valid);
					mismatch_count++;
				end else begin
					want = expected_counts.pop_front();
					if (got.frame_count !== want.frame_count) begin
						$display("%0t: frame_count expected %0d, got %0d",
							$time, want.frame_count, got.frame_count);
						mismatch_count++;
					end
					if (got.label_valid !== want.label_valid) begin
						$display("%0t: label_valid expected %0b, got %0b",
							$time, want.label_valid, got.label_valid);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Offer characters; hold an offered one until taken, pause at drain marks
	always @(negedge clk) begin : drive_chars
		char_item_t item;
		logic offer;
		offer = 1'b0;
		if (!(char_bus.valid && !char_taken)) begin
			if (arst_n && char_q.size() > 0) begin
				if (char_q[0].drain) begin
					if (expected_counts.size() == 0)
						void'(char_q.pop_front());
				end else if ($urandom_range(0, 99) >= send_idle_pct) begin
					item = char_q.pop_front();
					offer = 1'b1;
					char_bus.char_code <= item.code;
					char_bus.last_char <= item.last;
				end
			end
			char_bus.valid <= offer;
		end
	end

	// Accept results with random stalls and one long hold-off
	always @(negedge clk) begin : drive_result_ready
		if (hold_left > 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else if (arst_n && phase_no == HOLD_PHASE && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic [7:0] pick_space();
		return $urandom_range(0, 1) ? CHAR_SPACE : 8'(CHAR_TAB + $urandom_range(0, 4));
	endfunction

	task automatic append_number(inout byte_q_t lbl, input longint unsigned v,
			input int width);
		byte_q_t digs;
		do begin
			digs.push_front(8'(CHAR_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);
		while (digs.size() < width)
			digs.push_front(CHAR_ZERO);
		foreach (digs[i])
			lbl.insert(lbl.size(), digs[i]);
	endtask

	task automatic enqueue_label(byte_q_t lbl);
		foreach (lbl[i])
			char_q.insert(char_q.size(), char_item_t'{code: lbl[i],
				last: (i == lbl.size() - 1), drain: 1'b0});
	endtask

	task automatic enqueue_text(string s);
		byte_q_t lbl;
		for (int i = 0; i < s.len(); i++)
			lbl.insert(lbl.size(), s[i]);
		enqueue_label(lbl);
	endtask

	// Build a well-formed label, mostly within range
	task automatic build_good_label(input longint unsigned nom, output byte_q_t lbl);
		int nf;
		int unsigned r;
		longint unsigned v;
		lbl = {};
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) lbl.insert(lbl.size(), pick_space());
		r = $urandom_range(0, 9);
		if (r < 2)
			lbl.insert(lbl.size(), CHAR_MINUS);
		else if (r == 2)
			lbl.insert(lbl.size(), CHAR_PLUS);
		nf = $urandom_range(2, 4);
		for (int k = 4 - nf; k < 4; k++) begin
			r = $urandom_range(0, 99);
			if (r >= 97) begin
				// long digit run to drive the field into saturation
				repeat ($urandom_range(7, 12))
					lbl.insert(lbl.size(), 8'(CHAR_ZERO + $urandom_range(0, 9)));
			end else begin
				case (k)
					0: v = (r < 60) ? $urandom_range(0, 23) :
						(r < 85) ? $urandom_range(0, MAX_HOURS) :
						MAX_HOURS - 1 + $urandom_range(0, 2);
					1, 2: v = (r < 90) ? $urandom_range(0, 59) : $urandom_range(60, 99);
					default: v = (r < 90) ? $urandom_range(0, nom - 1) :
						nom + $urandom_range(0, 2);
				endcase
				append_number(lbl, v, ($urandom_range(0, 9) == 0) ? 1 : 2);
			end
			if (k < 3)
				lbl.insert(lbl.size(), CHAR_COLON);
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) lbl.insert(lbl.size(), pick_space());
	endtask

	// Damage a label in one place, or replace it with a bare number
	task automatic break_label(inout byte_q_t lbl);
		case ($urandom_range(0, 6))
			0: lbl.insert($urandom_range(0, lbl.size()), 8'($urandom_range(0, 255)));
			1: lbl.insert($urandom_range(0, lbl.size()), CHAR_COLON);
			2: lbl.insert($urandom_range(1, lbl.size()), pick_space());
			3: lbl.insert($urandom_range(0, lbl.size()),
				$urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
			4: begin
				lbl.insert(lbl.size(), CHAR_COLON);
				append_number(lbl, $urandom_range(0, 9), 2);
			end
			5: lbl.insert(lbl.size(), CHAR_COLON);
			default: begin
				lbl = {};
				append_number(lbl, $urandom_range(0, 99), 2);
			end
		endcase
	endtask

	task automatic wait_drained();
		while (char_q.size() != 0 || char_bus.valid || expected_counts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_nominal(logic [NOMINAL_W-1:0] v);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Stimulus: directed labels, then random phases over several frame rates
	initial begin : stimulus
		logic [NOMINAL_W-1:0] phase_nom[PHASES];
		longint unsigned nom;
		byte_q_t lbl;
		int sent;
		int unsigned roll;
		char_bus.valid = 1'b0;
		char_bus.char_code = '0;
		char_bus.last_char = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		result_bus.ready = 1'b0;
		phase_nom = '{NOMINAL_RESET, 16'd1, 16'hFFFF, 16'd0, 16'd24,
			16'($urandom_range(1, 65535)), NOMINAL_RESET};

		// directed labels at the reset frame rate
		enqueue_text("00:00:00:00");
		enqueue_text("-00:00");
		enqueue_text("+01:02:03:04");
		enqueue_text(" \t12:34:56:29\n");
		enqueue_text("1000000:59:59:29");
		enqueue_text("1000001:00:00:00");
		enqueue_text("99999999:00:00:00");
		enqueue_text("00:00:99999999");
		enqueue_text("60:00");
		enqueue_text("00:59:00:30");
		enqueue_text("59:29");
		enqueue_text("00:60:00:00");
		enqueue_text(" ");
		enqueue_text(":");
		enqueue_text("1:2:3:4:5");
		enqueue_text("12");
		enqueue_text(":12:00");
		enqueue_text("12::00");
		enqueue_text("12:00:");
		enqueue_text("12 :00");
		enqueue_text("12:00 x");
		enqueue_text("-+12:00");
		enqueue_text("12:-00");
		enqueue_text("12:0a");
		enqueue_text("-23:59:59:29  ");

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 1; p < PHASES; p++) begin
			wait_drained();
			phase_no = p;
			send_idle_pct = (p < 3) ? 30 : (p < 5) ? 81 : 0;
			recv_idle_pct = (p < 3) ? 81 : (p < 5) ? 30 : 0;
			write_nominal(phase_nom[p]);
			nom = (phase_nom[p] == 0) ? 1 : phase_nom[p];
			if (phase_nom[p] == 16'hFFFF)
				enqueue_text("-1000000:59:59:65534");
			sent = 0;
			while (sent < CHARS_PER_PHASE) begin
				// keep the sender busy while the receiver holds off
				if (p != HOLD_PHASE && $urandom_range(0, 19) == 0)
					char_q.insert(char_q.size(),
						char_item_t'{code: '0, last: 1'b0, drain: 1'b1});
				roll = $urandom_range(0, 99);
				if (roll < 90) begin
					build_good_label(nom, lbl);
					if (roll >= 70)
						break_label(lbl);
				end else begin
					lbl = {};
					repeat ($urandom_range(1, 12))
						lbl.insert(lbl.size(), 8'($urandom_range(0, 255)));
				end
				sent += lbl.size();
				enqueue_label(lbl);
			end
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tcp_pkg.sv
sv/tcp_if.sv
sv/tcp_ctrl.sv
sv/tcp_datapath.sv
sv/timecode_text_parser.sv
test/timecode_text_parser_test.sv
